// ===== src/frvs_pkg.sv =====
package frvs_pkg;

   // Field and register widths.
   localparam int DIST_W = 21;
   localparam int INV_W  = 24;
   localparam int BIAS_W = 25;
   localparam int OUT_W  = 16;
   localparam int FRAC_W = 16;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 25;

   localparam logic [CSR_IDX_W-1:0] CSR_INV_RANGE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BIAS = 1'b1;

   // 255.0 with 8 fraction bits.
   localparam logic [OUT_W-1:0] FULL_SCALE = 16'd65280;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   // Rounded smoothstep value of texel idx for a ramp of the given size.
   // With n = 2*idx+1 and d = 2*entries, the value is
   // floor((510*n*n*(3d-2n) + d^3) / (2*d^3)), found by counting the
   // multiples of 2*d^3 that fit under the numerator. Elaboration only.
   function automatic logic [7:0] ramp_value(input int unsigned idx,
                                             input int unsigned entries);
      longint unsigned n;
      longint unsigned d;
      longint unsigned d3;
      longint unsigned num;
      logic [7:0]      v;
      n   = 64'(2) * 64'(idx) + 64'(1);
      d   = 64'(2) * 64'(entries);
      d3  = d * d * d;
      num = 64'(510) * n * n * (64'(3) * d - 64'(2) * n) + d3;
      v   = 8'd0;
      for (int k = 1; k < 256; k++) begin
         if (64'(k) * 64'(2) * d3 <= num) begin
            v = 8'(k);
         end
      end
      return v;
   endfunction

endpackage

// ===== src/fog_ramp_visibility_sampler_top.sv =====
// Pipeline: a word accepted on req passes through the six register stages
// (product, bias, coordinate, texel select, lookup, blend) before rsp.
// Throughput: one word per cycle; six pipeline stages move independently,
// so a stalled result only blocks the input once every stage holds a word.
// Reset: synchronous, active high; clears all stage valid bits and sets
// inverse_range and offset_bias to zero. The ramp table is constant logic
// and needs no clearing pass.
module fog_ramp_visibility_sampler_top #(
   parameter int RAMP_ENTRIES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input channel.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [frvs_pkg::DIST_W-1:0]       req_distance,
   // Result channel.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [frvs_pkg::OUT_W-1:0]        rsp_fog_factor,
   output logic [frvs_pkg::OUT_W-1:0]        rsp_visibility,
   // Configuration writes.
   input  logic                              csr_wr_en,
   input  frvs_pkg::csr_index_type           csr_index,
   input  logic [frvs_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int STAGES = 6;
   localparam int PROD_W = frvs_pkg::DIST_W + frvs_pkg::INV_W;
   // u in Q.16: the product shifted down by 8, plus the signed bias.
   localparam int UW     = PROD_W - 8 + 2;
   localparam int IW     = $clog2(RAMP_ENTRIES);
   // x = u * RAMP_ENTRIES - 0.5 needs room for the scale and the offset.
   localparam int XW     = UW + IW + 1;
   localparam int FW     = frvs_pkg::FRAC_W;

   localparam logic signed [XW-1:0] ENTRIES_S = XW'(RAMP_ENTRIES);
   localparam logic signed [XW-1:0] HALF_TEXEL = XW'(32768);
   localparam logic signed [XW-1:0] TOP_X =
      XW'(longint'(RAMP_ENTRIES - 1) * 64'sd65536);
   localparam logic [IW-1:0]        LAST_IDX = IW'(RAMP_ENTRIES - 1);

   // The ramp table is built at elaboration from the smoothstep curve.
   logic [7:0] rom_tbl [RAMP_ENTRIES];

   for (genvar g = 0; g < RAMP_ENTRIES; g++) begin : g_rom
      localparam logic [7:0] VAL = frvs_pkg::ramp_value(g, RAMP_ENTRIES);
      assign rom_tbl[g] = VAL;
   end

   // Configuration registers.
   logic [frvs_pkg::INV_W-1:0]         inv_range_ff, inv_range_in;
   logic signed [frvs_pkg::BIAS_W-1:0] offset_bias_ff, offset_bias_in;

   always_comb begin
      inv_range_in   = inv_range_ff;
      offset_bias_in = offset_bias_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            frvs_pkg::CSR_INV_RANGE: begin
               inv_range_in = csr_wdata[frvs_pkg::INV_W-1:0];
            end
            frvs_pkg::CSR_OFFSET_BIAS: begin
               offset_bias_in = $signed(csr_wdata[frvs_pkg::BIAS_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_range_ff   <= '0;
         offset_bias_ff <= '0;
      end else begin
         inv_range_ff   <= inv_range_in;
         offset_bias_ff <= offset_bias_in;
      end
   end

   // Pipeline control. Each stage takes a new word when it is empty or
   // when the stage after it is taking its word, so bubbles close up
   // while the output is stalled.
   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] stage_en;

   always_comb begin
      stage_en[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = stage_en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = valid_ff[STAGES-1];

   // Stage 1: distance times inverse range, exact in Q.24.
   logic [PROD_W-1:0] prod_ff, prod_in;

   assign prod_in = PROD_W'(req_distance) * PROD_W'(inv_range_ff);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prod_ff <= prod_in;
      end
   end

   // Stage 2: drop 8 bits to Q.16 and add the bias.
   logic signed [UW-1:0] u_ff, u_in;

   assign u_in = $signed({2'b00, prod_ff[PROD_W-1:8]}) + UW'(offset_bias_ff);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         u_ff <= u_in;
      end
   end

   // Stage 3: texel coordinate x = u * RAMP_ENTRIES - 0.5 in Q.16.
   logic signed [XW-1:0] x_ff, x_in;
   logic signed [XW-1:0] u_ext;

   assign u_ext = XW'(u_ff);
   assign x_in  = XW'(u_ext * ENTRIES_S) - HALF_TEXEL;

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         x_ff <= x_in;
      end
   end

   // Stage 4: choose the two texels and the blend fraction. Outside the
   // outer texel centers both texels are the edge texel and the fraction
   // is zero, which gives the edge value exactly.
   logic [IW-1:0] idx_a_ff, idx_a_in;
   logic [IW-1:0] idx_b_ff, idx_b_in;
   logic [FW-1:0] frac4_ff, frac4_in;
   logic          x_low;
   logic          x_high;

   assign x_low  = x_ff[XW-1] || (x_ff == '0);
   assign x_high = (x_ff >= TOP_X);

   always_comb begin
      if (x_low) begin
         idx_a_in = '0;
         idx_b_in = '0;
         frac4_in = '0;
      end else if (x_high) begin
         idx_a_in = LAST_IDX;
         idx_b_in = LAST_IDX;
         frac4_in = '0;
      end else begin
         idx_a_in = x_ff[FW +: IW];
         idx_b_in = x_ff[FW +: IW] + IW'(1);
         frac4_in = x_ff[FW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         idx_a_ff <= idx_a_in;
         idx_b_ff <= idx_b_in;
         frac4_ff <= frac4_in;
      end
   end

   // Stage 5: table lookups.
   logic [7:0]    tex_a_ff, tex_a_in;
   logic [7:0]    tex_b_ff, tex_b_in;
   logic [FW-1:0] frac5_ff;

   assign tex_a_in = rom_tbl[idx_a_ff];
   assign tex_b_in = rom_tbl[idx_b_ff];

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         tex_a_ff <= tex_a_in;
         tex_b_ff <= tex_b_in;
         frac5_ff <= frac4_ff;
      end
   end

   // Stage 6: blend. The product is truncated by 8 bits; a falling pair
   // would truncate toward zero, which the magnitude form gives.
   logic [frvs_pkg::OUT_W-1:0] factor_ff, factor_in;
   logic [frvs_pkg::OUT_W-1:0] vis_ff, vis_in;
   logic                       rising;
   logic [7:0]                 step_mag;
   logic [FW+7:0]              blend_prod;
   logic [frvs_pkg::OUT_W:0]   base;
   logic [frvs_pkg::OUT_W:0]   raw_factor;

   assign rising     = (tex_b_ff >= tex_a_ff);
   assign step_mag   = rising ? (tex_b_ff - tex_a_ff) : (tex_a_ff - tex_b_ff);
   assign blend_prod = (FW + 8)'(frac5_ff) * (FW + 8)'(step_mag);
   assign base       = {1'b0, tex_a_ff, 8'h00};
   assign raw_factor = rising ? (base + {1'b0, blend_prod[FW+7:8]})
                              : (base - {1'b0, blend_prod[FW+7:8]});

   always_comb begin
      if (raw_factor > {1'b0, frvs_pkg::FULL_SCALE}) begin
         factor_in = frvs_pkg::FULL_SCALE;
      end else begin
         factor_in = raw_factor[frvs_pkg::OUT_W-1:0];
      end
      vis_in = frvs_pkg::FULL_SCALE - factor_in;
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         factor_ff <= factor_in;
         vis_ff    <= vis_in;
      end
   end

   assign rsp_fog_factor = factor_ff;
   assign rsp_visibility = vis_ff;

   // The input is only held off when every stage holds a word.
   a_stall_only_when_full: assert property (
      @(posedge clock) disable iff (reset)
      req_stall |-> (valid_ff == {STAGES{1'b1}})
   ) else $error("input stalled while a pipeline stage is empty");

   // The second texel is the first or its right neighbor.
   a_texel_pair: assert property (
      @(posedge clock) disable iff (reset)
      valid_ff[3] |-> (idx_b_ff == idx_a_ff || idx_b_ff == idx_a_ff + IW'(1))
   ) else $error("texel pair not adjacent");

   // A delivered factor never exceeds full scale.
   a_factor_range: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fog_factor <= frvs_pkg::FULL_SCALE)
   ) else $error("fog factor above full scale");

   // Reset empties the pipeline.
   a_reset_empty: assert property (
      @(posedge clock)
      $past(reset) |-> (valid_ff == '0)
   ) else $error("pipeline not empty after reset");

endmodule

// ===== tb/fog_ramp_visibility_sampler_top_tb.sv =====
module fog_ramp_visibility_sampler_top_tb;

   // The ramp size used for the block under test and for the local predictor.
   localparam int TEXELS = 64;
   // The long receiver hold-off, in cycles. It is long enough to fill every
   // pipeline stage so that the input side has to stall.
   localparam int LONG_HOLD = 300;
   localparam int RANDOM_ITEMS = 900;
   localparam logic [frvs_pkg::DIST_W-1:0] DIST_MAX = '1;

   // The expected fog factor and visibility for one distance word.
   typedef struct packed {
      logic [frvs_pkg::OUT_W-1:0] fog_factor;
      logic [frvs_pkg::OUT_W-1:0] visibility;
   } fog_pair_type;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [frvs_pkg::DIST_W-1:0]     req_distance = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [frvs_pkg::OUT_W-1:0]      rsp_fog_factor;
   logic [frvs_pkg::OUT_W-1:0]      rsp_visibility;
   logic                            csr_wr_en = 1'b0;
   frvs_pkg::csr_index_type         csr_index = frvs_pkg::CSR_INV_RANGE;
   logic [frvs_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   fog_ramp_visibility_sampler_top #(
      .RAMP_ENTRIES (TEXELS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_distance   (req_distance),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_fog_factor (rsp_fog_factor),
      .rsp_visibility (rsp_visibility),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The local copy of the ramp table and of the two configuration registers.
   // The registers are only updated while the block is idle, so the copy here
   // always matches what the block used for any word in flight.
   int                                  ramp_tbl [TEXELS];
   logic [frvs_pkg::INV_W-1:0]          inv_range_cfg = '0;
   logic signed [frvs_pkg::BIAS_W-1:0]  bias_cfg = '0;

   // Distances around the texel boundaries for a scale of exactly one.
   int probe_dist [10] = '{0, 1, 2, 3, 100, 128, 253, 254, 255, 256};

   // Distances waiting to be sent; the head is the word on the bus while
   // req_valid is high. It is popped only when the word is accepted.
   logic [frvs_pkg::DIST_W-1:0] distance_q [$];
   // Expected results, oldest first.
   fog_pair_type                fog_expect_q [$];

   int mismatches = 0;
   int tx_gap_max = 0;
   int rx_gap_max = 0;
   int tx_wait = 0;
   int rx_wait = 0;
   int rx_hold = 0;
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   bit hold_request = 1'b0;

   // Computes the fog factor and visibility for one distance from the current
   // register copy. The texel coordinate is u*TEXELS - 0.5 in Q.16. Outside
   // the outer texel centers the edge texel is used; inside them the two
   // neighboring texels are blended with a 16-bit fraction, and the blended
   // part is truncated toward zero.
   function automatic fog_pair_type predict_fog(input logic [frvs_pkg::DIST_W-1:0] dist_in);
      longint unsigned prod;
      longint          u;
      longint          x;
      int              lo;
      int              frac;
      int              a;
      int              b;
      int              f;
      fog_pair_type    r;
      prod = 64'(dist_in) * 64'(inv_range_cfg);
      u    = longint'(prod >> 8) + longint'(bias_cfg);
      x    = u * TEXELS - 32768;
      if (x <= 0) begin
         f = ramp_tbl[0] * 256;
      end else if (x >= longint'(TEXELS - 1) * 65536) begin
         f = ramp_tbl[TEXELS-1] * 256;
      end else begin
         lo   = int'(x >>> 16);
         frac = int'(x & 64'hFFFF);
         a    = ramp_tbl[lo];
         b    = ramp_tbl[lo+1];
         f    = a * 256 + (frac * (b - a)) / 256;
      end
      if (f > int'(frvs_pkg::FULL_SCALE)) begin
         f = int'(frvs_pkg::FULL_SCALE);
      end
      r.fog_factor = frvs_pkg::OUT_W'(f);
      r.visibility = frvs_pkg::FULL_SCALE - frvs_pkg::OUT_W'(f);
      return r;
   endfunction

   // Input side, sampling half. A word is taken when valid is high and the
   // block does not stall; its expectation is queued at that same edge.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         fog_expect_q.push_back(predict_fog(req_distance));
         void'(distance_q.pop_front());
         req_taken = 1'b1;
      end
   end

   // Input side, driving half. The bus may only change when nothing is on it
   // or the word on it was just taken. After each taken word a fresh idle gap
   // is drawn; valid never looks at the stall.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_taken) begin
            req_taken = 1'b0;
            tx_wait   = $urandom_range(0, tx_gap_max);
         end
         if (tx_wait > 0) begin
            tx_wait--;
            req_valid <= 1'b0;
         end else if (distance_q.size() > 0) begin
            req_valid    <= 1'b1;
            req_distance <= distance_q[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side, checking half. Every taken result is compared field by
   // field with the oldest expectation.
   always @(posedge clock) begin : check_rsp
      fog_pair_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_taken = 1'b1;
         if (fog_expect_q.size() == 0) begin
            $display("%0t: unexpected result: fog_factor %0d visibility %0d",
                     $time, rsp_fog_factor, rsp_visibility);
            mismatches++;
         end else begin
            want = fog_expect_q.pop_front();
            if (rsp_fog_factor !== want.fog_factor) begin
               $display("%0t: fog_factor mismatch: expected %0d, got %0d",
                        $time, want.fog_factor, rsp_fog_factor);
               mismatches++;
            end
            if (rsp_visibility !== want.visibility) begin
               $display("%0t: visibility mismatch: expected %0d, got %0d",
                        $time, want.visibility, rsp_visibility);
               mismatches++;
            end
         end
      end
   end

   // Result side, stall half. After each taken result a random wait is drawn.
   // A long hold-off, when requested, is counted down here and overrides it.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request) begin
            rx_hold      = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rx_wait   = $urandom_range(0, rx_gap_max);
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_stall <= 1'b1;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Waits until every queued word has been taken and every expected result
   // has come back, then lets the pipeline drain a little more.
   task automatic settle();
      while (distance_q.size() != 0 || fog_expect_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
   endtask

   // One register write. The local copy keeps only the register's own width,
   // so bits above it are dropped just as the block drops them.
   task automatic write_csr(input frvs_pkg::csr_index_type idx,
                            input logic [frvs_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == frvs_pkg::CSR_INV_RANGE) begin
         inv_range_cfg = data[frvs_pkg::INV_W-1:0];
      end else begin
         bias_cfg = data[frvs_pkg::BIAS_W-1:0];
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic configure(input logic [frvs_pkg::INV_W-1:0] inv,
                            input logic [frvs_pkg::BIAS_W-1:0] bias);
      settle();
      write_csr(frvs_pkg::CSR_INV_RANGE, frvs_pkg::CSR_DATA_W'(inv));
      write_csr(frvs_pkg::CSR_OFFSET_BIAS, frvs_pkg::CSR_DATA_W'(bias));
   endtask

   initial begin
      longint unsigned n;
      longint unsigned d;
      longint unsigned d3;
      longint unsigned num;
      longint unsigned inv;
      longint unsigned start_dist;
      longint unsigned start_max;
      longint unsigned span;
      longint unsigned pick_dist;
      int              bits;
      int              count;
      int              sent;

      // The ramp is the rounded smoothstep at each texel center, worked out
      // exactly in integers with ties rounded up.
      for (int i = 0; i < TEXELS; i++) begin
         n   = 64'(2 * i + 1);
         d   = 64'(2 * TEXELS);
         d3  = d * d * d;
         num = 64'(510) * n * n * (64'(3) * d - 64'(2) * n) + d3;
         ramp_tbl[i] = (num / (64'(2) * d3) > 255) ? 255 : int'(num / (64'(2) * d3));
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Straight after reset both registers are zero, so every distance sits
      // below the first texel center.
      distance_q.push_back('0);
      distance_q.push_back(DIST_MAX);

      // With a scale of exactly one, u is the distance times 256, which puts
      // the texel boundaries on small distances: 2 lands exactly on the first
      // center, 253 is inside the last pair, and 254 lands exactly on the last
      // center.
      configure(24'h010000, '0);
      foreach (probe_dist[k]) begin
         distance_q.push_back(frvs_pkg::DIST_W'(probe_dist[k]));
      end
      distance_q.push_back(DIST_MAX);

      // Largest scale with the most negative bias: the ramp is crossed
      // within one step of distance around 256.
      configure('1, 25'h1000000);
      distance_q.push_back('0);
      distance_q.push_back(frvs_pkg::DIST_W'(256));
      distance_q.push_back(frvs_pkg::DIST_W'(257));
      distance_q.push_back(frvs_pkg::DIST_W'(258));
      distance_q.push_back(DIST_MAX);

      // A scale write with a bit above the register width, which the block
      // must drop, and the largest positive bias, which lands above the last
      // center for every distance.
      settle();
      write_csr(frvs_pkg::CSR_INV_RANGE, 25'h1004000);
      write_csr(frvs_pkg::CSR_OFFSET_BIAS, 25'h0FFFFFF);
      distance_q.push_back('0);
      distance_q.push_back(frvs_pkg::DIST_W'(1000));

      // Back-pressure: the receiver holds off for a long stretch while words
      // keep coming with no gaps, so the pipeline fills and stalls the input.
      configure(24'h010000, 25'h1FFC000);
      tx_gap_max   = 0;
      rx_gap_max   = 0;
      hold_request = 1'b1;
      for (int k = 0; k < 60; k++) begin
         distance_q.push_back(frvs_pkg::DIST_W'($urandom_range(0, 400)));
      end

      // Random phases. Most use a fade window placed on a random start
      // distance so that the words walk across the ramp; the rest use raw
      // register values. The idle pressure on both sides changes per phase.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         settle();
         case ($urandom_range(0, 9))
            0: begin
               write_csr(frvs_pkg::CSR_INV_RANGE, frvs_pkg::CSR_DATA_W'($urandom));
               write_csr(frvs_pkg::CSR_OFFSET_BIAS, frvs_pkg::CSR_DATA_W'($urandom));
               start_dist = 0;
               span       = 0;
            end
            1: begin
               write_csr(frvs_pkg::CSR_INV_RANGE,
                         ($urandom_range(0, 1) == 0) ? '0 : 25'h0FFFFFF);
               write_csr(frvs_pkg::CSR_OFFSET_BIAS,
                         ($urandom_range(0, 1) == 0) ? '0 : 25'h1000000);
               start_dist = 0;
               span       = 0;
            end
            default: begin
               bits = $urandom_range(1, frvs_pkg::INV_W);
               inv  = 64'($urandom) & ((64'(1) << bits) - 1);
               if (inv == 0) begin
                  inv = 1;
               end
               // The start distance is kept small enough that the bias
               // needed to cancel it fits the register.
               start_max = (64'(1) << 32) / inv;
               if (start_max > 64'(DIST_MAX)) begin
                  start_max = 64'(DIST_MAX);
               end
               start_dist = 64'($urandom_range(0, 32'(start_max)));
               span       = (64'(1) << 24) / inv + 1;
               write_csr(frvs_pkg::CSR_INV_RANGE, frvs_pkg::CSR_DATA_W'(inv));
               write_csr(frvs_pkg::CSR_OFFSET_BIAS,
                         frvs_pkg::CSR_DATA_W'(-longint'((start_dist * inv) >> 8)));
            end
         endcase
         tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 3 : 17);
         rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 3 : 17);
         count = $urandom_range(20, 60);
         for (int k = 0; k < count; k++) begin
            if (span != 0 && $urandom_range(0, 3) != 0) begin
               pick_dist = start_dist + 64'($urandom_range(0, 32'(span)));
               if (pick_dist > 64'(DIST_MAX)) begin
                  pick_dist = 64'(DIST_MAX);
               end
            end else begin
               pick_dist = 64'($urandom);
            end
            distance_q.push_back(frvs_pkg::DIST_W'(pick_dist));
         end
         sent += count;
      end

      settle();
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Guard against a hang; a correct run ends far earlier than this.
   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/frvs_pkg.sv
src/fog_ramp_visibility_sampler_top.sv
tb/fog_ramp_visibility_sampler_top_tb.sv
